FILE: hw/rtl/mep_pkg.sv
// Shared constants, register map and types for the Mandelbrot escape-time pixel unit.
`timescale 1ns / 1ps

package mep_pkg;

	// Number formats: coordinates Q4.F, iteration values Q12.F
	localparam int COORD_FRAC_BITS = 28;
	localparam int MAX_DEPTH       = 1024;
	localparam int PALETTE_SIZE    = 256;

	// Field and register widths
	localparam int PIX_W    = 12;
	localparam int ORG_W    = 32;
	localparam int STEP_W   = 31;
	localparam int ITER_W   = 11;
	localparam int LIMIT_W  = 7;
	localparam int COUNT_W  = 9;
	localparam int COLOUR_W = 8;
	localparam int DATA_W   = 32;

	// Derived datapath widths
	localparam int CW     = COORD_FRAC_BITS + 4;
	localparam int ZW     = COORD_FRAC_BITS + 12;
	localparam int PW     = 2 * ZW;
	localparam int HALF   = ZW / 2;
	localparam int KEY_W  = PW - 2 * COORD_FRAC_BITS;
	localparam int PROD_W = PIX_W + STEP_W;
	localparam int SUM_W0 = (ORG_W > PROD_W + 1) ? ORG_W + 1 : PROD_W + 2;
	localparam int SUM_W  = (SUM_W0 > CW) ? SUM_W0 : CW;

	// Register map
	localparam int CFG_REGS  = 8;
	localparam int REG_IDX_W = $clog2(CFG_REGS);
	localparam int ADDR_W    = REG_IDX_W + 2;

	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_REAL   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_IMAG   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_STEP_REAL     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_STEP_IMAG     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MAX_ITER      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ESCAPE_LIMIT  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_COLOR_MODE    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_COLOR_COUNT   = 3'd7;

	// Colour modes
	localparam logic MODE_ITER = 1'b0;
	localparam logic MODE_DIST = 1'b1;

	typedef struct packed {
		logic [ORG_W-1:0]   origin_real;
		logic [ORG_W-1:0]   origin_imag;
		logic [STEP_W-1:0]  step_real;
		logic [STEP_W-1:0]  step_imag;
		logic [ITER_W-1:0]  max_iterations;
		logic [LIMIT_W-1:0] escape_limit;
		logic               color_mode;
		logic [COUNT_W-1:0] color_count;
	} mep_cfg_t;

	localparam mep_cfg_t CFG_RESET = '{
		origin_real:    32'hE999_999A,
		origin_imag:    32'h1000_0000,
		step_real:      31'h0010_0000,
		step_imag:      31'h0010_0000,
		max_iterations: 11'd20,
		escape_limit:   7'd4,
		color_mode:     MODE_ITER,
		color_count:    9'd256
	};

	// Point c handed from front end to back end, two's complement Q4.F
	typedef struct packed {
		logic [CW-1:0] cr;
		logic [CW-1:0] ci;
	} mep_point_t;

	// Colour request from the iteration engine to the remainder unit
	typedef struct packed {
		logic               escaped;
		logic [KEY_W-1:0]   key;
		logic [COUNT_W-1:0] count;
	} mep_colour_req_t;

endpackage

FILE: hw/rtl/mep_pixel_if.sv
// Pixel request channel: valid/ready handshake carrying one pixel coordinate.
`timescale 1ns / 1ps

interface mep_pixel_if;
	import mep_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

FILE: hw/rtl/mep_result_if.sv
// Result channel: valid/ready handshake carrying escape flag and colour index.
`timescale 1ns / 1ps

interface mep_result_if;
	import mep_pkg::*;

	logic                valid;
	logic                ready;
	logic                escaped;
	logic [COLOUR_W-1:0] color_index;

	modport source (output valid, output escaped, output color_index, input ready);
	modport sink (input valid, input escaped, input color_index, output ready);
endinterface

FILE: hw/rtl/mep_front.sv
// Front end: maps a pixel coordinate to the saturated point c and pushes it to the queue.
`timescale 1ns / 1ps

module mep_front (
	input  logic                clk,
	input  logic                arst_n,
	mep_pixel_if.sink           pixel,
	input  mep_pkg::mep_cfg_t   cfg,
	output logic                push_valid,
	input  logic                push_ready,
	output mep_pkg::mep_point_t push_data
);
	import mep_pkg::*;

	localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

	logic              v_s1;
	logic [PROD_W-1:0] prod_r_s1;
	logic [PROD_W-1:0] prod_i_s1;
	logic [SUM_W-1:0]  sum_r;
	logic [SUM_W-1:0]  sum_i;
	logic [SUM_W-CW:0] top_r;
	logic [SUM_W-CW:0] top_i;

	// Stage 1 moves on whenever its slot is empty or drains into the queue
	assign pixel.ready = !v_s1 || push_ready;
	assign push_valid  = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pixel.ready) begin
			v_s1 <= pixel.valid;
		end
	end

	// Column and row offsets
	always_ff @(posedge clk) begin
		if (pixel.valid && pixel.ready) begin
			prod_r_s1 <= PROD_W'(pixel.pixel_x) * PROD_W'(cfg.step_real);
			prod_i_s1 <= PROD_W'(pixel.pixel_y) * PROD_W'(cfg.step_imag);
		end
	end

	// Origin plus column offset and origin minus row offset, saturated to the coordinate range
	always_comb begin
		sum_r = {{(SUM_W-ORG_W){cfg.origin_real[ORG_W-1]}}, cfg.origin_real}
			+ {{(SUM_W-PROD_W){1'b0}}, prod_r_s1};
		sum_i = {{(SUM_W-ORG_W){cfg.origin_imag[ORG_W-1]}}, cfg.origin_imag}
			- {{(SUM_W-PROD_W){1'b0}}, prod_i_s1};
		top_r = sum_r[SUM_W-1:CW-1];
		top_i = sum_i[SUM_W-1:CW-1];

		if ((&top_r) || !(|top_r)) begin
			push_data.cr = sum_r[CW-1:0];
		end else begin
			push_data.cr = sum_r[SUM_W-1] ? CMIN : CMAX;
		end

		if ((&top_i) || !(|top_i)) begin
			push_data.ci = sum_i[CW-1:0];
		end else begin
			push_data.ci = sum_i[SUM_W-1] ? CMIN : CMAX;
		end
	end

endmodule

FILE: hw/rtl/mep_queue.sv
// Small FIFO of points between the front end and the iteration engine.
`timescale 1ns / 1ps

module mep_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  mep_pkg::mep_point_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output mep_pkg::mep_point_t pop_data
);
	import mep_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mep_point_t       slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10: begin
					count_q <= count_q + CNT_W'(1);
				end
				2'b01: begin
					count_q <= count_q - CNT_W'(1);
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

FILE: hw/rtl/mep_iter.sv
// Back end: iterates z = z*z + c with shared split multipliers and tests for escape.
`timescale 1ns / 1ps

module mep_iter (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mep_pkg::mep_cfg_t        cfg,
	input  logic                     pop_valid,
	output logic                     pop_ready,
	input  mep_pkg::mep_point_t      pop_data,
	output logic                     req_valid,
	input  logic                     req_ready,
	output mep_pkg::mep_colour_req_t req
);
	import mep_pkg::*;

	localparam int F       = COORD_FRAC_BITS;
	localparam int LANES   = 3;
	localparam int LANE_RR = 0;
	localparam int LANE_II = 1;
	localparam int LANE_RI = 2;
	localparam int HI_W    = ZW - HALF;
	localparam int BS_W    = HI_W + 1;
	localparam int MW      = ZW + BS_W;

	localparam logic [ZW-1:0] ZMAX = {1'b0, {(ZW-1){1'b1}}};
	localparam logic [ZW-1:0] ZMIN = {1'b1, {(ZW-1){1'b0}}};

	// Sequencer codes: one pass of MLO..UPD per z update
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MLO  = 3'd1;
	localparam logic [2:0] ST_MHI  = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_COMB = 3'd4;
	localparam logic [2:0] ST_UPD  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]           state_q;
	logic [CW-1:0]        cr_q;
	logic [CW-1:0]        ci_q;
	logic signed [ZW-1:0] zr_q;
	logic signed [ZW-1:0] zi_q;
	logic [ITER_W-1:0]    k_q;
	logic [ITER_W-1:0]    depth_q;
	logic [MW-1:0]        plo_q [LANES];
	logic [MW-1:0]        phi_q [LANES];
	logic [PW-1:0]        prod_q [LANES];
	logic [PW-1:0]        re_q;
	logic [PW-1:0]        im_q;
	logic [PW-1:0]        mag_q;
	mep_colour_req_t      req_q;

	logic signed [ZW-1:0]   opa [LANES];
	logic [ZW-1:0]          opb [LANES];
	logic signed [BS_W-1:0] bsel [LANES];
	logic signed [MW-1:0]   mul [LANES];
	logic [PW-1:0]          wide [LANES];

	logic [ITER_W-1:0]       depth;
	logic [COUNT_W-1:0]      count;
	logic [PW-F-ZW:0]        re_top;
	logic [PW-F-ZW+1:0]      im_top;
	logic [ZW-1:0]           nr;
	logic [ZW-1:0]           ni;
	logic [ZW:0]             sr;
	logic [ZW:0]             si;
	logic [ZW-1:0]           zr_n;
	logic [ZW-1:0]           zi_n;
	logic [KEY_W-1:0]        sq_mag;
	logic [ITER_W-1:0]       idx;
	logic [KEY_W-1:0]        key;
	logic                    hit;

	assign pop_ready = (state_q == ST_IDLE);
	assign req_valid = (state_q == ST_DONE);
	assign req       = req_q;

	// Clamped iteration depth and palette size
	always_comb begin
		depth = (32'(cfg.max_iterations) > 32'(MAX_DEPTH)) ? ITER_W'(MAX_DEPTH)
			: cfg.max_iterations;
		count = (32'(cfg.color_count) > 32'(PALETTE_SIZE)) ? COUNT_W'(PALETTE_SIZE)
			: cfg.color_count;
	end

	// Three lanes (zr*zr, zi*zi, zr*zi), each a ZW x BS_W multiplier fed one half of b
	always_comb begin
		opa[LANE_RR] = zr_q;
		opb[LANE_RR] = zr_q;
		opa[LANE_II] = zi_q;
		opb[LANE_II] = zi_q;
		opa[LANE_RI] = zr_q;
		opb[LANE_RI] = zi_q;
		for (int l = 0; l < LANES; l++) begin
			if (state_q == ST_MHI) begin
				bsel[l] = {opb[l][ZW-1], opb[l][ZW-1:HALF]};
			end else begin
				bsel[l] = {{(BS_W-HALF){1'b0}}, opb[l][HALF-1:0]};
			end
			mul[l]  = opa[l] * bsel[l];
			wide[l] = ({{(PW-MW){phi_q[l][MW-1]}}, phi_q[l]} << HALF)
				+ {{(PW-MW){plo_q[l][MW-1]}}, plo_q[l]};
		end
	end

	// Rescale, saturate, add c, saturate again; escape test on |z|^2
	always_comb begin
		re_top = re_q[PW-1:F+ZW-1];
		im_top = im_q[PW-1:F+ZW-2];

		if ((&re_top) || !(|re_top)) begin
			nr = re_q[F+ZW-1:F];
		end else begin
			nr = re_q[PW-1] ? ZMIN : ZMAX;
		end
		if ((&im_top) || !(|im_top)) begin
			ni = im_q[F+ZW-2:F-1];
		end else begin
			ni = im_q[PW-1] ? ZMIN : ZMAX;
		end

		sr = {nr[ZW-1], nr} + {{(ZW+1-CW){cr_q[CW-1]}}, cr_q};
		si = {ni[ZW-1], ni} + {{(ZW+1-CW){ci_q[CW-1]}}, ci_q};
		zr_n = (sr[ZW] == sr[ZW-1]) ? sr[ZW-1:0] : (sr[ZW] ? ZMIN : ZMAX);
		zi_n = (si[ZW] == si[ZW-1]) ? si[ZW-1:0] : (si[ZW] ? ZMIN : ZMAX);

		sq_mag = mag_q[PW-1:2*F];
		hit    = ({{(KEY_W-LIMIT_W){1'b0}}, cfg.escape_limit} <= sq_mag);
		idx    = k_q - ITER_W'(1);
		key    = (cfg.color_mode == MODE_DIST) ? sq_mag : {{(KEY_W-ITER_W){1'b0}}, idx};
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= (depth == '0) ? ST_DONE : ST_MLO;
					end
				end
				ST_MLO: begin
					state_q <= ST_MHI;
				end
				ST_MHI: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_COMB;
				end
				ST_COMB: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if ((k_q != '0 && hit) || k_q == depth_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MLO;
					end
				end
				ST_DONE: begin
					if (req_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					cr_q    <= pop_data.cr;
					ci_q    <= pop_data.ci;
					zr_q    <= '0;
					zi_q    <= '0;
					k_q     <= '0;
					depth_q <= depth;
					req_q   <= '{escaped: 1'b0, key: '0, count: count};
				end
			end
			ST_MLO: begin
				for (int l = 0; l < LANES; l++) begin
					plo_q[l] <= mul[l];
				end
			end
			ST_MHI: begin
				for (int l = 0; l < LANES; l++) begin
					phi_q[l] <= mul[l];
				end
			end
			ST_SUM: begin
				for (int l = 0; l < LANES; l++) begin
					prod_q[l] <= wide[l];
				end
			end
			ST_COMB: begin
				re_q  <= prod_q[LANE_RR] - prod_q[LANE_II];
				im_q  <= prod_q[LANE_RI];
				mag_q <= prod_q[LANE_RR] + prod_q[LANE_II];
			end
			ST_UPD: begin
				if (k_q != '0 && hit) begin
					req_q.escaped <= 1'b1;
					req_q.key     <= key;
				end else if (k_q != depth_q) begin
					zr_q <= zr_n;
					zi_q <= zi_n;
					k_q  <= k_q + ITER_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hw/rtl/mep_rem.sv
// Colour unit: restoring remainder of the key by the palette size, one bit per cycle.
`timescale 1ns / 1ps

module mep_rem (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  mep_pkg::mep_colour_req_t req,
	mep_result_if.source             result
);
	import mep_pkg::*;

	localparam int BIT_W = $clog2(KEY_W);

	localparam logic [1:0] R_IDLE = 2'd0;
	localparam logic [1:0] R_RUN  = 2'd1;
	localparam logic [1:0] R_OUT  = 2'd2;

	logic [1:0]          state_q;
	logic [KEY_W-1:0]    key_q;
	logic [COUNT_W-1:0]  count_q;
	logic [COUNT_W-1:0]  rem_q;
	logic [BIT_W-1:0]    bit_q;
	logic                esc_q;
	logic [COLOUR_W-1:0] colour_q;

	logic [COUNT_W:0]   trial;
	logic [COUNT_W-1:0] rem_n;
	logic               direct;

	assign req_ready          = (state_q == R_IDLE);
	assign result.valid       = (state_q == R_OUT);
	assign result.escaped     = esc_q;
	assign result.color_index = colour_q;

	// Background and an empty palette both give colour zero at once
	assign direct = !req.escaped || (req.count == '0);

	// Shift in the next key bit, subtract the modulus where it fits
	always_comb begin
		trial = {rem_q, key_q[KEY_W-1]};
		if (trial >= {1'b0, count_q}) begin
			rem_n = COUNT_W'(trial - {1'b0, count_q});
		end else begin
			rem_n = COUNT_W'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
		end else begin
			case (state_q)
				R_IDLE: begin
					if (req_valid) begin
						state_q <= direct ? R_OUT : R_RUN;
					end
				end
				R_RUN: begin
					if (bit_q == '0) begin
						state_q <= R_OUT;
					end
				end
				R_OUT: begin
					if (result.ready) begin
						state_q <= R_IDLE;
					end
				end
				default: begin
					state_q <= R_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			R_IDLE: begin
				if (req_valid) begin
					esc_q    <= req.escaped;
					colour_q <= '0;
					key_q    <= req.key;
					count_q  <= req.count;
					rem_q    <= '0;
					bit_q    <= BIT_W'(KEY_W - 1);
				end
			end
			R_RUN: begin
				rem_q <= rem_n;
				key_q <= key_q << 1;
				bit_q <= bit_q - BIT_W'(1);
				if (bit_q == '0) begin
					colour_q <= rem_n[COLOUR_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hw/rtl/mandelbrot_escape_pixel_unit.sv
// Mandelbrot escape-time pixel unit: registers, front end, queue, iteration engine, colour unit.
// Each z update passes through the shared split multipliers in the MLO, MHI, SUM, COMB and UPD
// states; a background pixel or an empty palette skips the colour remainder, and the remainder
// of one pixel overlaps the iteration of the next.
// arst_n (asynchronous, active low) empties the pipeline and queue and loads the register defaults.
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	mep_pixel_if.sink                   pixel,
	mep_result_if.source                result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mep_pkg::ADDR_W-1:0]  paddr,
	input  logic [mep_pkg::DATA_W-1:0]  pwdata,
	output logic [mep_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import mep_pkg::*;

	mep_cfg_t               cfg_q;
	logic [REG_IDX_W-1:0]   reg_idx;
	logic                   push_valid;
	logic                   push_ready;
	mep_point_t             push_data;
	logic                   pop_valid;
	logic                   pop_ready;
	mep_point_t             pop_data;
	logic                   req_valid;
	logic                   req_ready;
	mep_colour_req_t        req;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];

	// Register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_ORIGIN_REAL: begin
					cfg_q.origin_real <= pwdata[ORG_W-1:0];
				end
				REG_ORIGIN_IMAG: begin
					cfg_q.origin_imag <= pwdata[ORG_W-1:0];
				end
				REG_STEP_REAL: begin
					cfg_q.step_real <= pwdata[STEP_W-1:0];
				end
				REG_STEP_IMAG: begin
					cfg_q.step_imag <= pwdata[STEP_W-1:0];
				end
				REG_MAX_ITER: begin
					cfg_q.max_iterations <= pwdata[ITER_W-1:0];
				end
				REG_ESCAPE_LIMIT: begin
					cfg_q.escape_limit <= pwdata[LIMIT_W-1:0];
				end
				REG_COLOR_MODE: begin
					cfg_q.color_mode <= pwdata[0];
				end
				REG_COLOR_COUNT: begin
					cfg_q.color_count <= pwdata[COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Register read-back
	always_comb begin
		case (reg_idx)
			REG_ORIGIN_REAL: begin
				prdata = DATA_W'(cfg_q.origin_real);
			end
			REG_ORIGIN_IMAG: begin
				prdata = DATA_W'(cfg_q.origin_imag);
			end
			REG_STEP_REAL: begin
				prdata = DATA_W'(cfg_q.step_real);
			end
			REG_STEP_IMAG: begin
				prdata = DATA_W'(cfg_q.step_imag);
			end
			REG_MAX_ITER: begin
				prdata = DATA_W'(cfg_q.max_iterations);
			end
			REG_ESCAPE_LIMIT: begin
				prdata = DATA_W'(cfg_q.escape_limit);
			end
			REG_COLOR_MODE: begin
				prdata = DATA_W'(cfg_q.color_mode);
			end
			REG_COLOR_COUNT: begin
				prdata = DATA_W'(cfg_q.color_count);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	mep_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixel),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	mep_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	mep_iter u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req)
	);

	mep_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.result    (result)
	);

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the Mandelbrot escape-time pixel unit, with a bit-exact predictor.
`timescale 1ns / 1ps

module tb;
	import mep_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int PHASES      = 12;
	localparam int DEEP_PHASE  = 5;
	localparam int DEEP_ITEMS  = 8;
	localparam int PHASE_ITEMS = 72;

	// Wide enough for exact Q12.F products and their sums
	typedef logic signed [127:0] acc_t;

	typedef struct {
		logic [PIX_W-1:0]    x;
		logic [PIX_W-1:0]    y;
		logic                escaped;
		logic [COLOUR_W-1:0] colour;
	} pixel_verdict_t;

	typedef struct {
		bit                  is_write;
		logic [REG_IDX_W-1:0] reg_idx;
		logic [DATA_W-1:0]   value;
		logic [PIX_W-1:0]    x;
		logic [PIX_W-1:0]    y;
		bit                  known;
		logic                escaped;
		logic [COLOUR_W-1:0] colour;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	mep_pixel_if  pix_req ();
	mep_result_if pix_res ();

	mandelbrot_escape_pixel_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pix_req),
		.result  (pix_res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	mep_cfg_t       active_setting;
	pixel_verdict_t expected_pixels[$];
	stim_row_t      directed_rows[$];

	int cycle_count    = 0;
	int mismatches     = 0;
	int escaped_cnt    = 0;
	int background_cnt = 0;
	int writes_done    = 0;
	int gap_pct        = 25;
	int stall_pct      = 15;

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Saturate to a signed field of the given width
	function automatic acc_t clamp_to(input acc_t v, input int bits);
		acc_t top;
		acc_t bottom;
		top = 1;
		top = (top <<< (bits - 1)) - 1;
		bottom = -top - 1;
		if (v > top)
			return top;
		if (v < bottom)
			return bottom;
		return v;
	endfunction

	// Escape-time evaluation of one pixel under the given register setting
	function automatic pixel_verdict_t predict_escape(input mep_cfg_t s,
			input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
		pixel_verdict_t v;
		acc_t o_r, o_i, st_r, st_i, px, py;
		acc_t cr, ci, zr, zi, sq_re, im_new, sq_mag, limit, key, count, depth, rem;
		v.x = x;
		v.y = y;
		v.escaped = 1'b0;
		v.colour = '0;
		o_r = $signed(s.origin_real);
		o_i = $signed(s.origin_imag);
		st_r = s.step_real;
		st_i = s.step_imag;
		px = x;
		py = y;
		cr = clamp_to(o_r + px * st_r, CW);
		ci = clamp_to(o_i - py * st_i, CW);
		depth = s.max_iterations;
		if (depth > MAX_DEPTH)
			depth = MAX_DEPTH;
		count = s.color_count;
		if (count > PALETTE_SIZE)
			count = PALETTE_SIZE;
		limit = s.escape_limit;
		zr = 0;
		zi = 0;
		for (int i = 0; i < depth; i++) begin
			sq_re = clamp_to((zr * zr - zi * zi) >>> COORD_FRAC_BITS, ZW);
			im_new = clamp_to((zr * zi) >>> (COORD_FRAC_BITS - 1), ZW);
			zr = clamp_to(sq_re + cr, ZW);
			zi = clamp_to(im_new + ci, ZW);
			sq_mag = (zr * zr + zi * zi) >>> (2 * COORD_FRAC_BITS);
			if (sq_mag >= limit) begin
				key = sq_mag;
				if (s.color_mode == MODE_ITER)
					key = i;
				rem = (count == 0) ? acc_t'(0) : key % count;
				v.escaped = 1'b1;
				v.colour = rem[COLOUR_W-1:0];
				break;
			end
		end
		return v;
	endfunction

	// Directed table builders
	function automatic void add_write(input logic [REG_IDX_W-1:0] idx,
			input logic [DATA_W-1:0] val);
		stim_row_t r;
		r = '{default: '0};
		r.is_write = 1'b1;
		r.reg_idx = idx;
		r.value = val;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_pixel(input int x, input int y);
		stim_row_t r;
		r = '{default: '0};
		r.x = PIX_W'(x);
		r.y = PIX_W'(y);
		directed_rows.push_back(r);
	endfunction

	function automatic void add_pixel_known(input int x, input int y, input logic esc,
			input int colour);
		stim_row_t r;
		r = '{default: '0};
		r.x = PIX_W'(x);
		r.y = PIX_W'(y);
		r.known = 1'b1;
		r.escaped = esc;
		r.colour = COLOUR_W'(colour);
		directed_rows.push_back(r);
	endfunction

	// Random junk above a register's width, which the block must ignore
	function automatic logic [DATA_W-1:0] dirty_upper(input logic [DATA_W-1:0] v, input int w);
		if ($urandom_range(0, 3) == 0)
			return v | ($urandom << w);
		return v;
	endfunction

	function automatic int pick_idle_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 10;
			default: return 40;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_step();
		case ($urandom_range(0, 9))
			0: return $urandom & 32'h7FFF_FFFF;
			1: return '0;
			default: return $urandom_range(1 << 14, 1 << 19);
		endcase
	endfunction

	// APB write: setup then access; the bus is left selected and released by the pixel sender
	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (idx)
			REG_ORIGIN_REAL:  active_setting.origin_real = val[ORG_W-1:0];
			REG_ORIGIN_IMAG:  active_setting.origin_imag = val[ORG_W-1:0];
			REG_STEP_REAL:    active_setting.step_real = val[STEP_W-1:0];
			REG_STEP_IMAG:    active_setting.step_imag = val[STEP_W-1:0];
			REG_MAX_ITER:     active_setting.max_iterations = val[ITER_W-1:0];
			REG_ESCAPE_LIMIT: active_setting.escape_limit = val[LIMIT_W-1:0];
			REG_COLOR_MODE:   active_setting.color_mode = val[0];
			REG_COLOR_COUNT:  active_setting.color_count = val[COUNT_W-1:0];
			default: ;
		endcase
		writes_done++;
	endtask

	// Hold off requests until every outstanding result has been returned
	task automatic wait_drained();
		if (pix_req.valid)
			pix_req.valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
	endtask

	// Issue one pixel request and queue its expected result on acceptance
	task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
			input bit known, input logic esc, input logic [COLOUR_W-1:0] colour);
		pixel_verdict_t v;
		if (psel) begin
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
		end
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			pix_req.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		pix_req.valid <= 1'b1;
		pix_req.pixel_x <= x;
		pix_req.pixel_y <= y;
		do @(posedge clk); while (pix_req.ready !== 1'b1);
		if (known) begin
			v.x = x;
			v.y = y;
			v.escaped = esc;
			v.colour = colour;
		end else
			v = predict_escape(active_setting, x, y);
		expected_pixels.push_back(v);
	endtask

	// New random view of the plane; only while the unit is idle
	task automatic program_random_setting(input bit deep);
		logic [DATA_W-1:0] v;
		wait_drained();
		if ($urandom_range(0, 9) == 0)
			v = $urandom;
		else
			v = $urandom_range(0, 805306368) - 32'd671088640;
		reg_write(REG_ORIGIN_REAL, v);
		if ($urandom_range(0, 9) == 0)
			v = $urandom;
		else
			v = $urandom_range(0, 536870912) - 32'd134217728;
		reg_write(REG_ORIGIN_IMAG, v);
		reg_write(REG_STEP_REAL, dirty_upper(pick_step(), STEP_W));
		reg_write(REG_STEP_IMAG, dirty_upper(pick_step(), STEP_W));
		if (deep)
			v = $urandom_range(1000, 2047);
		else if ($urandom_range(0, 19) == 0)
			v = '0;
		else
			v = $urandom_range(1, 48);
		reg_write(REG_MAX_ITER, dirty_upper(v, ITER_W));
		if ($urandom_range(0, 7) == 0)
			v = $urandom_range(0, 127);
		else
			v = $urandom_range(1, 8);
		reg_write(REG_ESCAPE_LIMIT, dirty_upper(v, LIMIT_W));
		reg_write(REG_COLOR_MODE, dirty_upper($urandom_range(0, 1), 1));
		if ($urandom_range(0, 3) == 0)
			v = $urandom_range(0, 511);
		else
			v = $urandom_range(1, 256);
		reg_write(REG_COLOR_COUNT, dirty_upper(v, COUNT_W));
	endtask

	// Result sink: stalls ready in random bursts
	initial begin
		pix_res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				pix_res.ready <= 1'b0;
				repeat ($urandom_range(1, 15) - 1) @(posedge clk);
			end else
				pix_res.ready <= 1'b1;
		end
	end

	// Compare each returned result with the oldest expectation
	always @(posedge clk) begin
		pixel_verdict_t want;
		if (arst_n && pix_res.valid === 1'b1 && pix_res.ready === 1'b1) begin
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with no request outstanding: escaped=%0d colour=%0d",
						pix_res.escaped, pix_res.color_index);
			end else begin
				want = expected_pixels.pop_front();
				if (pix_res.escaped !== want.escaped || pix_res.color_index !== want.colour) begin
					mismatches++;
					if (mismatches <= 10)
						$display("pixel (%0d,%0d): expected escaped=%0d colour=%0d, got escaped=%0d colour=%0d",
							want.x, want.y, want.escaped, want.colour,
							pix_res.escaped, pix_res.color_index);
				end
				if (pix_res.escaped === 1'b1)
					escaped_cnt++;
				else
					background_cnt++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("no progress: stopped after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_req.valid = 1'b0;
		pix_req.pixel_x = '0;
		pix_req.pixel_y = '0;
		active_setting = '{
			origin_real:    32'hE999_999A,
			origin_imag:    32'h1000_0000,
			step_real:      31'h0010_0000,
			step_imag:      31'h0010_0000,
			max_iterations: 11'd20,
			escape_limit:   7'd4,
			color_mode:     MODE_ITER,
			color_count:    9'd256
		};

		// Directed table. At reset c = -1.4 + 1.0i, which escapes on step 2 with |z|^2 = 26.
		add_pixel_known(0, 0, 1'b1, 2);
		add_pixel(4095, 4095);
		add_pixel(4095, 0);
		add_pixel(0, 4095);
		// zero escape limit: escapes straight away
		add_write(REG_ESCAPE_LIMIT, 0);
		add_pixel_known(1234, 567, 1'b1, 0);
		// zero iterations: always background
		add_write(REG_ESCAPE_LIMIT, 4);
		add_write(REG_MAX_ITER, 0);
		add_pixel_known(0, 0, 1'b0, 0);
		// zero colour count
		add_write(REG_MAX_ITER, 20);
		add_write(REG_COLOR_COUNT, 0);
		add_pixel_known(0, 0, 1'b1, 0);
		// colour by distance; count above the palette size wraps at the palette
		add_write(REG_COLOR_MODE, MODE_DIST);
		add_write(REG_COLOR_COUNT, 511);
		add_pixel_known(0, 0, 1'b1, 26);
		add_write(REG_COLOR_COUNT, 7);
		add_pixel_known(0, 0, 1'b1, 5);
		// c saturating at both ends of the coordinate range
		add_write(REG_ORIGIN_REAL, 32'h7FFF_FFFF);
		add_write(REG_ORIGIN_IMAG, 32'h8000_0000);
		add_write(REG_STEP_REAL, 32'h7FFF_FFFF);
		add_write(REG_STEP_IMAG, 32'h7FFF_FFFF);
		add_write(REG_ESCAPE_LIMIT, 127);
		add_pixel(4095, 4095);
		add_pixel(0, 0);
		add_write(REG_ORIGIN_REAL, 32'h8000_0000);
		add_write(REG_ORIGIN_IMAG, 32'h7FFF_FFFF);
		add_pixel(0, 4095);
		add_pixel(4095, 0);
		// c = 0 never escapes; iteration count above the depth cap
		add_write(REG_ORIGIN_REAL, 0);
		add_write(REG_ORIGIN_IMAG, 0);
		add_write(REG_STEP_REAL, 0);
		add_write(REG_STEP_IMAG, 0);
		add_write(REG_MAX_ITER, 2047);
		add_write(REG_ESCAPE_LIMIT, 4);
		add_pixel_known(4095, 4095, 1'b0, 0);
		// slow point near the set boundary, -0.75 + 0.1i
		add_write(REG_ORIGIN_REAL, 32'hF400_0000);
		add_write(REG_ORIGIN_IMAG, 32'h0199_999A);
		add_write(REG_MAX_ITER, 1024);
		add_write(REG_COLOR_MODE, MODE_ITER);
		add_write(REG_COLOR_COUNT, 256);
		add_pixel(0, 0);
		add_write(REG_ESCAPE_LIMIT, 64);
		add_pixel(0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_write) begin
				wait_drained();
				reg_write(directed_rows[i].reg_idx, directed_rows[i].value);
			end else
				send_pixel(directed_rows[i].x, directed_rows[i].y, directed_rows[i].known,
					directed_rows[i].escaped, directed_rows[i].colour);
		end

		// Random phases; the last one runs with no idling on either side
		for (int ph = 0; ph < PHASES; ph++) begin
			int n_items;
			program_random_setting(ph == DEEP_PHASE);
			if (ph == PHASES - 1) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = pick_idle_pct();
				stall_pct = pick_idle_pct();
			end
			n_items = (ph == DEEP_PHASE) ? DEEP_ITEMS : PHASE_ITEMS;
			for (int k = 0; k < n_items; k++) begin
				if (expected_pixels.size() != 0 && $urandom_range(0, 59) == 0)
					wait_drained();
				send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)),
					1'b0, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (200) @(posedge clk);

		$display("%0d pixels returned (%0d escaped, %0d background) over %0d register writes",
			escaped_cnt + background_cnt, escaped_cnt, background_cnt, writes_done);
		$display("covered reset view, zero limit/depth/count, saturated c, depth cap, both colour modes");
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
